@@ src/cbz_pkg.sv @@
// Shared constants and types for the cubic Bezier segment generator.
package cbz_pkg;

	// Segments per curve; must be a power of two.
	localparam int STEPS      = 1024;
	localparam int STEPS_LOG2 = $clog2(STEPS);

	localparam int STEP_W    = 11;
	localparam int IDX_W     = STEPS_LOG2 + 1;
	localparam int COORD_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Each interpolation level adds STEPS_LOG2 fraction bits plus one guard bit.
	localparam int L1_W  = COORD_W + STEPS_LOG2 + 1;
	localparam int L2_W  = L1_W + STEPS_LOG2 + 1;
	localparam int L3_W  = L2_W + STEPS_LOG2 + 1;
	localparam int SHIFT = 3 * STEPS_LOG2;

	localparam int AXES   = 2;
	localparam int POINTS = 4;
	// Four curve evaluations per item: bit 0 selects the axis, bit 1 the end.
	localparam int EVALS  = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [L1_W-1:0]    lvl1_t;
	typedef logic signed [L2_W-1:0]    lvl2_t;
	typedef logic signed [L3_W-1:0]    lvl3_t;
	typedef logic        [IDX_W-1:0]   idx_t;
	typedef logic        [STEP_W-1:0]  step_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CTRL0_X = 3'd0,
		REG_CTRL0_Y = 3'd1,
		REG_CTRL1_X = 3'd2,
		REG_CTRL1_Y = 3'd3,
		REG_CTRL2_X = 3'd4,
		REG_CTRL2_Y = 3'd5,
		REG_CTRL3_X = 3'd6,
		REG_CTRL3_Y = 3'd7
	} cfg_reg_t;

endpackage

@@ src/cubic_bezier_segment_generator_core.sv @@
// Pipelined de Casteljau evaluator that turns a step index into one curve segment.
//
//  channel   direction  handshake              payload
//  step      in         step_valid/step_stall  step_index
//  seg       out        seg_valid/seg_stall    seg_start_x/y, seg_end_x/y, final_segment
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// Five register stages: index clamp, first, second and third interpolation
// level, then truncation into the output register. One item is taken every
// cycle unless step_stall is high. Each stage holds its item while the stage
// after it is full and stalled, so bubbles are squeezed out and step_stall
// rises only when all five stages are full. Reset clears valid bits and the
// control points.
module cubic_bezier_segment_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_valid,
	output logic                                step_stall,
	input  logic        [cbz_pkg::STEP_W-1:0]   step_index,
	input  logic                                cfg_we,
	input  logic        [cbz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [cbz_pkg::COORD_W-1:0]  cfg_data,
	output logic                                seg_valid,
	input  logic                                seg_stall,
	output logic signed [cbz_pkg::COORD_W-1:0]  seg_start_x,
	output logic signed [cbz_pkg::COORD_W-1:0]  seg_start_y,
	output logic signed [cbz_pkg::COORD_W-1:0]  seg_end_x,
	output logic signed [cbz_pkg::COORD_W-1:0]  seg_end_y,
	output logic                                final_segment
);

	localparam cbz_pkg::lvl3_t TRUNC_BIAS =
		cbz_pkg::lvl3_t'((64'd1 << cbz_pkg::SHIFT) - 64'd1);

	// One interpolation level: a*STEPS + (b - a)*i, exact in the wider type.
	function automatic cbz_pkg::lvl1_t lerp1(input cbz_pkg::coord_t a,
		input cbz_pkg::coord_t b, input cbz_pkg::idx_t i);
		cbz_pkg::lvl1_t ae;
		cbz_pkg::lvl1_t be;
		cbz_pkg::lvl1_t d;
		logic signed [cbz_pkg::L1_W+cbz_pkg::IDX_W:0] prod;
		ae   = cbz_pkg::lvl1_t'(a);
		be   = cbz_pkg::lvl1_t'(b);
		d    = be - ae;
		prod = (cbz_pkg::L1_W+cbz_pkg::IDX_W+1)'(d) *
			$signed((cbz_pkg::L1_W+cbz_pkg::IDX_W+1)'(i));
		return cbz_pkg::lvl1_t'(ae <<< cbz_pkg::STEPS_LOG2) + cbz_pkg::lvl1_t'(prod);
	endfunction

	function automatic cbz_pkg::lvl2_t lerp2(input cbz_pkg::lvl1_t a,
		input cbz_pkg::lvl1_t b, input cbz_pkg::idx_t i);
		cbz_pkg::lvl2_t ae;
		cbz_pkg::lvl2_t be;
		cbz_pkg::lvl2_t d;
		logic signed [cbz_pkg::L2_W+cbz_pkg::IDX_W:0] prod;
		ae   = cbz_pkg::lvl2_t'(a);
		be   = cbz_pkg::lvl2_t'(b);
		d    = be - ae;
		prod = (cbz_pkg::L2_W+cbz_pkg::IDX_W+1)'(d) *
			$signed((cbz_pkg::L2_W+cbz_pkg::IDX_W+1)'(i));
		return cbz_pkg::lvl2_t'(ae <<< cbz_pkg::STEPS_LOG2) + cbz_pkg::lvl2_t'(prod);
	endfunction

	function automatic cbz_pkg::lvl3_t lerp3(input cbz_pkg::lvl2_t a,
		input cbz_pkg::lvl2_t b, input cbz_pkg::idx_t i);
		cbz_pkg::lvl3_t ae;
		cbz_pkg::lvl3_t be;
		cbz_pkg::lvl3_t d;
		logic signed [cbz_pkg::L3_W+cbz_pkg::IDX_W:0] prod;
		ae   = cbz_pkg::lvl3_t'(a);
		be   = cbz_pkg::lvl3_t'(b);
		d    = be - ae;
		prod = (cbz_pkg::L3_W+cbz_pkg::IDX_W+1)'(d) *
			$signed((cbz_pkg::L3_W+cbz_pkg::IDX_W+1)'(i));
		return cbz_pkg::lvl3_t'(ae <<< cbz_pkg::STEPS_LOG2) + cbz_pkg::lvl3_t'(prod);
	endfunction

	// Control points, indexed by axis then point.
	cbz_pkg::coord_t ctrl_q [cbz_pkg::AXES][cbz_pkg::POINTS];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	cbz_pkg::idx_t   idx_prev_s1, idx_cur_s1, idx_prev_s2, idx_cur_s2;
	cbz_pkg::idx_t   idx_prev_s3, idx_cur_s3;
	logic            final_s1, final_s2, final_s3, final_s4, final_s5;
	cbz_pkg::lvl1_t  l1_s2 [cbz_pkg::EVALS][3];
	cbz_pkg::lvl2_t  l2_s3 [cbz_pkg::EVALS][2];
	cbz_pkg::lvl3_t  l3_s4 [cbz_pkg::EVALS];
	cbz_pkg::coord_t res_s5 [cbz_pkg::EVALS];

	cbz_pkg::step_t  clamped;
	cbz_pkg::lvl1_t  l1_d [cbz_pkg::EVALS][3];
	cbz_pkg::lvl2_t  l2_d [cbz_pkg::EVALS][2];
	cbz_pkg::lvl3_t  l3_d [cbz_pkg::EVALS];
	cbz_pkg::coord_t res_d [cbz_pkg::EVALS];

	// A stage takes a new item when it is empty or its item moves on.
	assign en_s5      = !v_s5 || !seg_stall;
	assign en_s4      = !v_s4 || en_s5;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign step_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < cbz_pkg::AXES; a++) begin
				for (int p = 0; p < cbz_pkg::POINTS; p++) begin
					ctrl_q[a][p] <= '0;
				end
			end
		end else if (cfg_we) begin
			unique case (cbz_pkg::cfg_reg_t'(cfg_index))
				cbz_pkg::REG_CTRL0_X: ctrl_q[0][0] <= cfg_data;
				cbz_pkg::REG_CTRL0_Y: ctrl_q[1][0] <= cfg_data;
				cbz_pkg::REG_CTRL1_X: ctrl_q[0][1] <= cfg_data;
				cbz_pkg::REG_CTRL1_Y: ctrl_q[1][1] <= cfg_data;
				cbz_pkg::REG_CTRL2_X: ctrl_q[0][2] <= cfg_data;
				cbz_pkg::REG_CTRL2_Y: ctrl_q[1][2] <= cfg_data;
				cbz_pkg::REG_CTRL3_X: ctrl_q[0][3] <= cfg_data;
				cbz_pkg::REG_CTRL3_Y: ctrl_q[1][3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Out-of-range indexes fold onto the first or the last segment.
	always_comb begin
		if (step_index == '0) begin
			clamped = cbz_pkg::step_t'(1);
		end else if (step_index > cbz_pkg::step_t'(cbz_pkg::STEPS)) begin
			clamped = cbz_pkg::step_t'(cbz_pkg::STEPS);
		end else begin
			clamped = step_index;
		end
	end

	always_comb begin
		for (int e = 0; e < cbz_pkg::EVALS; e++) begin
			l1_d[e][0] = lerp1(ctrl_q[e % 2][0], ctrl_q[e % 2][1],
				(e >= 2) ? idx_cur_s1 : idx_prev_s1);
			l1_d[e][1] = lerp1(ctrl_q[e % 2][1], ctrl_q[e % 2][2],
				(e >= 2) ? idx_cur_s1 : idx_prev_s1);
			l1_d[e][2] = lerp1(ctrl_q[e % 2][2], ctrl_q[e % 2][3],
				(e >= 2) ? idx_cur_s1 : idx_prev_s1);
			l2_d[e][0] = lerp2(l1_s2[e][0], l1_s2[e][1],
				(e >= 2) ? idx_cur_s2 : idx_prev_s2);
			l2_d[e][1] = lerp2(l1_s2[e][1], l1_s2[e][2],
				(e >= 2) ? idx_cur_s2 : idx_prev_s2);
			l3_d[e]    = lerp3(l2_s3[e][0], l2_s3[e][1],
				(e >= 2) ? idx_cur_s3 : idx_prev_s3);
			// Arithmetic shift floors, so negative values get a bias first.
			res_d[e] = cbz_pkg::coord_t'((l3_s4[e] +
				(l3_s4[e][cbz_pkg::L3_W-1] ? TRUNC_BIAS : '0)) >>> cbz_pkg::SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= step_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_cur_s1  <= cbz_pkg::idx_t'(clamped);
			idx_prev_s1 <= cbz_pkg::idx_t'(clamped - cbz_pkg::step_t'(1));
			final_s1    <= (clamped == cbz_pkg::step_t'(cbz_pkg::STEPS));
		end
		if (en_s2) begin
			l1_s2       <= l1_d;
			idx_cur_s2  <= idx_cur_s1;
			idx_prev_s2 <= idx_prev_s1;
			final_s2    <= final_s1;
		end
		if (en_s3) begin
			l2_s3       <= l2_d;
			idx_cur_s3  <= idx_cur_s2;
			idx_prev_s3 <= idx_prev_s2;
			final_s3    <= final_s2;
		end
		if (en_s4) begin
			l3_s4    <= l3_d;
			final_s4 <= final_s3;
		end
		if (en_s5) begin
			res_s5   <= res_d;
			final_s5 <= final_s4;
		end
	end

	assign seg_valid     = v_s5;
	assign seg_start_x   = res_s5[0];
	assign seg_start_y   = res_s5[1];
	assign seg_end_x     = res_s5[2];
	assign seg_end_y     = res_s5[3];
	assign final_segment = final_s5;

	// The two parameters of one segment are always adjacent.
	a_idx_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (idx_prev_s1 + cbz_pkg::idx_t'(1)) == idx_cur_s1)
		else $error("segment indexes are not adjacent");

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && final_s1 |-> idx_cur_s1 == cbz_pkg::idx_t'(cbz_pkg::STEPS))
		else $error("final flag set on an inner segment");

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_s4 |=> v_s3 && $stable(final_s3) && $stable(idx_cur_s3))
		else $error("held item in third stage was lost or changed");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		step_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && seg_stall)
		else $error("input stalled while the pipeline has room");

endmodule
